// File: rtl/jms_pkg.sv
// Shared types and constants for the JPEG marker segmenter.
package jms_pkg;

  // Marker bytes and limits of the segment walk
  localparam logic [7:0] MARK_PREFIX = 8'hFF;
  localparam logic [7:0] MARK_SOI    = 8'hD8;
  localparam logic [7:0] MARK_EOI    = 8'hD9;
  localparam logic [7:0] MARK_SOS    = 8'hDA;
  localparam logic [7:0] KIND_SCAN   = 8'h00;
  localparam logic [31:0] HDR_MARGIN = 32'd11;
  localparam logic [31:0] MIN_FILE   = 32'd12;

  // Record queue between parser and output stage
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_START,
    PH_SEEK,
    PH_MARK,
    PH_LENHI,
    PH_LENLO,
    PH_SCAN,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] size;
    logic [7:0]  kind;
    logic        last;
    logic        done;
  } rec_t;

  // One queue entry; eoi asks the output stage to follow with an EOI record
  typedef struct packed {
    rec_t        rec;
    logic        eoi;
    logic [31:0] eoi_ofs;
  } qent_t;

endpackage

// File: rtl/jms_front.sv
// Parser front end: takes file bytes, walks marker segments, pushes records.
module jms_front #(
  parameter int OFFSET_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [31:0]   file_length_i,
  input  logic          accept_i,
  input  logic [7:0]    byte_value_i,
  output logic          push_o,
  output jms_pkg::qent_t entry_o
);
  import jms_pkg::*;

  localparam int P = OFFSET_BITS;
  localparam int W = (P + 1 > 33) ? P + 1 : 33;

  phase_e         phase_q, phase_d;
  logic [P-1:0]   pos_q;
  logic [P-1:0]   seg_start_q, seg_start_d;
  logic [7:0]     marker_q, marker_d;
  logic [7:0]     len_hi_q, len_hi_d;
  logic [P:0]     next_seg_q, next_seg_d;
  logic [P:0]     scan_start_q, scan_start_d;
  logic [7:0]     prev_q;
  logic [31:0]    file_length_q;

  logic [W-1:0]   len_w, pos_w, nseg_w, seg_w, scan_w;
  logic           len_ok, hdr_over, at_last, at_next, is_ff, eoi_tail;
  logic [15:0]    seglen;
  logic           seg_short;
  logic [16:0]    seg_total;
  logic [P:0]     seg_end;
  logic [W:0]     diff, diff2;
  logic           diff_neg;
  logic [31:0]    size_all, size_eoi;

  // Shared compares and sums
  assign len_w     = W'(file_length_q);
  assign pos_w     = W'(pos_q);
  assign nseg_w    = W'(next_seg_q);
  assign seg_w     = W'(seg_start_q);
  assign scan_w    = W'(scan_start_q);
  assign len_ok    = file_length_q >= MIN_FILE;
  assign hdr_over  = nseg_w >= (len_w - W'(HDR_MARGIN));
  assign at_last   = (file_length_q != 32'd0) && (pos_w == len_w - W'(1));
  assign at_next   = (W'(pos_q) == nseg_w);
  assign is_ff     = byte_value_i == MARK_PREFIX;
  assign eoi_tail  = (prev_q == MARK_PREFIX) && (byte_value_i == MARK_EOI);
  assign seglen    = {len_hi_q, byte_value_i};
  assign seg_short = seglen < 16'd2;
  assign seg_total = {1'b0, seglen} + 17'd2;
  assign seg_end   = {1'b0, seg_start_q} + (P+1)'(seg_total);

  // Scan data run length, clamped at zero
  assign diff      = {1'b0, len_w} - {1'b0, scan_w};
  assign diff2     = diff - (W+1)'(2);
  assign diff_neg  = diff[W];
  assign size_all  = diff_neg ? 32'd0 : diff[31:0];
  assign size_eoi  = (diff_neg || (diff[W-1:1] == '0)) ? 32'd0 : diff2[31:0];

  // Next state
  always_comb begin
    phase_d      = phase_q;
    seg_start_d  = seg_start_q;
    marker_d     = marker_q;
    len_hi_d     = len_hi_q;
    next_seg_d   = next_seg_q;
    scan_start_d = scan_start_q;
    unique case (phase_q)
      PH_START: begin
        if (pos_q == '0) begin
          if (!is_ff) phase_d = PH_DONE;
        end else if (prev_q == MARK_PREFIX && byte_value_i == MARK_SOI && len_ok) begin
          next_seg_d = (P+1)'(2);
          phase_d    = PH_SEEK;
        end else begin
          phase_d = PH_DONE;
        end
      end
      PH_SEEK: begin
        if (at_next) begin
          if (!len_ok || hdr_over || !is_ff) begin
            phase_d = PH_DONE;
          end else begin
            seg_start_d = pos_q;
            phase_d     = PH_MARK;
          end
        end
      end
      PH_MARK: begin
        marker_d = byte_value_i;
        phase_d  = PH_LENHI;
      end
      PH_LENHI: begin
        len_hi_d = byte_value_i;
        phase_d  = PH_LENLO;
      end
      PH_LENLO: begin
        if (seg_short) begin
          phase_d = PH_DONE;
        end else begin
          next_seg_d = seg_end;
          if (marker_q == MARK_SOS) begin
            scan_start_d = seg_end;
            phase_d      = PH_SCAN;
          end else begin
            phase_d = PH_SEEK;
          end
        end
      end
      PH_SCAN: begin
        if (at_last) phase_d = PH_DONE;
      end
      PH_DONE: ;
      default: phase_d = PH_DONE;
    endcase
  end

  // Record outputs
  always_comb begin
    push_o          = 1'b0;
    entry_o         = '0;
    entry_o.eoi_ofs = file_length_q - 32'd2;
    unique case (phase_q)
      PH_START: begin
        if (pos_q != '0 && prev_q == MARK_PREFIX && byte_value_i == MARK_SOI && len_ok) begin
          push_o              = accept_i;
          entry_o.rec.offset  = 32'd0;
          entry_o.rec.size    = 32'd2;
          entry_o.rec.kind    = MARK_SOI;
          entry_o.rec.last    = 1'b1;
        end
      end
      PH_LENLO: begin
        if (!seg_short) begin
          push_o              = accept_i;
          entry_o.rec.offset  = seg_w[31:0];
          entry_o.rec.size    = 32'(seg_total);
          entry_o.rec.kind    = marker_q;
          entry_o.rec.last    = 1'b1;
        end
      end
      PH_SCAN: begin
        if (at_last) begin
          push_o             = accept_i;
          entry_o.rec.offset = scan_w[31:0];
          entry_o.rec.kind   = KIND_SCAN;
          if (eoi_tail) begin
            entry_o.rec.size = size_eoi;
            entry_o.eoi      = 1'b1;
          end else begin
            entry_o.rec.size = size_all;
            entry_o.rec.last = 1'b1;
            entry_o.rec.done = 1'b1;
          end
        end
      end
      default: push_o = 1'b0;
    endcase
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_START;
      pos_q        <= '0;
      seg_start_q  <= P'(2);
      marker_q     <= '0;
      len_hi_q     <= '0;
      next_seg_q   <= (P+1)'(2);
      scan_start_q <= '0;
      prev_q       <= '0;
    end else if (accept_i) begin
      phase_q      <= phase_d;
      pos_q        <= pos_q + P'(1);
      seg_start_q  <= seg_start_d;
      marker_q     <= marker_d;
      len_hi_q     <= len_hi_d;
      next_seg_q   <= next_seg_d;
      scan_start_q <= scan_start_d;
      prev_q       <= byte_value_i;
    end
  end

  // File length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_length_q <= '0;
    end else if (cfg_we_i) begin
      file_length_q <= file_length_i;
    end
  end

  // Once parsing ends it stays ended
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DONE |=> phase_q == PH_DONE)
    else $error("parser left done phase");

  // Marker byte is always followed by the length high byte
  a_mark_to_lenhi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && phase_q == PH_MARK) |=> phase_q == PH_LENHI)
    else $error("marker byte not followed by length");

endmodule

// File: rtl/jms_queue.sv
// Short record queue between parser and output stage.
module jms_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  jms_pkg::qent_t entry_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output jms_pkg::qent_t entry_o
);
  import jms_pkg::*;

  qent_t                 slots_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_BITS-1:0]  count_q, count_d;
  logic                  do_push, do_pop;

  assign full_o  = count_q == QCNT_BITS'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign entry_o = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Occupancy
  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) count_d = count_q + QCNT_BITS'(1);
    else if (!do_push && do_pop) count_d = count_q - QCNT_BITS'(1);
  end

  // Pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
      count_q <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wr_ptr_q] <= entry_i;
  end

  // Parser never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("record pushed into full queue");

  // Occupancy never runs past the depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

// File: rtl/jms_back.sv
// Output stage: drains the record queue and adds the EOI beat after scan data.
module jms_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  jms_pkg::qent_t q_entry_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output jms_pkg::rec_t  out_rec_o
);
  import jms_pkg::*;

  logic        out_valid_q, out_valid_d;
  rec_t        out_rec_q, out_rec_d;
  logic        eoi_pend_q, eoi_pend_d;
  logic [31:0] eoi_ofs_q, eoi_ofs_d;
  logic        out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign q_pop_o     = out_free && !eoi_pend_q && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_rec_o   = out_rec_q;

  // Output register load
  always_comb begin
    out_valid_d = out_valid_q;
    out_rec_d   = out_rec_q;
    eoi_pend_d  = eoi_pend_q;
    eoi_ofs_d   = eoi_ofs_q;
    if (out_free) begin
      if (eoi_pend_q) begin
        out_valid_d      = 1'b1;
        out_rec_d.offset = eoi_ofs_q;
        out_rec_d.size   = 32'd2;
        out_rec_d.kind   = MARK_EOI;
        out_rec_d.last   = 1'b1;
        out_rec_d.done   = 1'b1;
        eoi_pend_d       = 1'b0;
      end else if (q_valid_i) begin
        out_valid_d = 1'b1;
        out_rec_d   = q_entry_i.rec;
        eoi_pend_d  = q_entry_i.eoi;
        eoi_ofs_d   = q_entry_i.eoi_ofs;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      eoi_pend_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      eoi_pend_q  <= eoi_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rec_q <= out_rec_d;
    eoi_ofs_q <= eoi_ofs_d;
  end

  // A pending EOI always sits behind a shown scan record
  a_eoi_behind_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eoi_pend_q |-> out_valid_q && !out_rec_q.last)
    else $error("EOI pending without scan record");

  // A taken scan record with EOI pending is followed by the EOI beat
  a_eoi_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (eoi_pend_q && !out_stall_i) |=> out_valid_q && out_rec_q.kind == MARK_EOI)
    else $error("EOI beat missing");

endmodule

// File: rtl/jpeg_marker_segmenter_unit.sv
// A record beat goes from its byte beat through the record queue to the output register;
// the EOI beat of a file that ends FF D9 is loaded once the scan-data beat is taken.
// Throughput: one byte beat per cycle; the parser pushes at most one queue entry
// per byte, and the scan-data entry that ends in FF D9 yields two output beats.
// The input stalls only while the four-entry record queue is full.
// Reset (rst_ni, async, active low) clears the parser, queue and output stage;
// file_length resets to zero.
module jpeg_marker_segmenter_unit #(
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] file_length_i,
  // Byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_value_i,
  // Record output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] record_offset_o,
  output logic [31:0] record_size_o,
  output logic [7:0]  record_kind_o,
  output logic        run_last_o,
  output logic        parse_done_o
);
  import jms_pkg::*;

  logic  in_accept, q_full, q_push, q_pop, q_valid;
  qent_t q_wr_entry, q_rd_entry;
  rec_t  out_rec;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;
  assign in_accept   = in_valid_i && !q_full;

  // Parser front end
  jms_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .file_length_i(file_length_i),
    .accept_i     (in_accept),
    .byte_value_i (byte_value_i),
    .push_o       (q_push),
    .entry_o      (q_wr_entry)
  );

  // Record queue
  jms_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(q_wr_entry),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .entry_o(q_rd_entry)
  );

  // Output stage
  jms_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_entry_i  (q_rd_entry),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rec_o  (out_rec)
  );

  assign record_offset_o = out_rec.offset;
  assign record_size_o   = out_rec.size;
  assign record_kind_o   = out_rec.kind;
  assign run_last_o      = out_rec.last;
  assign parse_done_o    = out_rec.done;

endmodule
